>>> sv/btd_pkg.sv
// Package for the button hold/tap detector.
// Holds the button count, the threshold reset value, Q1.16 constants and the sequencer states.
// No dependencies.
package btd_pkg;

  // Number of buttons in a mask
  localparam int unsigned BUTTONS = 16;
  localparam int unsigned IDX_W   = $clog2(BUTTONS);
  localparam int unsigned BTN_W   = 5;
  localparam int unsigned ACT_W   = 6;
  localparam int unsigned MASK_W  = 16;
  localparam int unsigned DT_W    = 20;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned PROG_W  = 17;
  localparam int unsigned FRAC_W  = 16;

  localparam logic [TICK_W-1:0] THRESHOLD_RESET = TICK_W'(500000);
  localparam logic [PROG_W-1:0] Q16_ONE         = PROG_W'(65536);
  localparam logic [BTN_W-1:0]  BTN_NONE        = BTN_W'(BUTTONS);

  // One quotient bit per divide step
  localparam int unsigned DIV_STEPS = FRAC_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } btd_state_e;

endpackage

>>> sv/btd_if.sv
// Handshake channels of the button hold/tap detector: input frame and result.
// Depends on btd_pkg for field widths.
interface btd_frame_if;
  logic                              valid;
  logic                              ready;
  logic [btd_pkg::MASK_W-1:0]        current_mask;
  logic [btd_pkg::MASK_W-1:0]        previous_mask;
  logic [btd_pkg::ACT_W-1:0]         action_index;
  logic [btd_pkg::DT_W-1:0]          delta_time;

  modport source (output valid, current_mask, previous_mask, action_index, delta_time,
                  input ready);
  modport sink   (input valid, current_mask, previous_mask, action_index, delta_time,
                  output ready);
endinterface

interface btd_result_if;
  logic                              valid;
  logic                              ready;
  logic                              accepted;
  logic                              holding;
  logic                              threshold_reached;
  logic                              tapped;
  logic                              held_released;
  logic [btd_pkg::TICK_W-1:0]        held_time;
  logic [btd_pkg::PROG_W-1:0]        progress;
  logic [btd_pkg::BTN_W-1:0]         locked_index;

  modport source (output valid, accepted, holding, threshold_reached, tapped,
                  held_released, held_time, progress, locked_index,
                  input ready);
  modport sink   (input valid, accepted, holding, threshold_reached, tapped,
                  held_released, held_time, progress, locked_index,
                  output ready);
endinterface

>>> sv/button_hold_tap_detector_top.sv
// Top level of the button hold/tap detector: hold tracking and a bit-serial progress divider.
// Depends on btd_pkg and the channel interfaces in btd_if.sv.
//
//  channel   dir  handshake       payload
//  frame_i   in   valid/ready     current_mask, previous_mask, action_index, delta_time
//  result_o  out  valid/ready     accepted, holding, pulses, held_time, progress, locked_index
//  cfg       in   cfg_we_i only   cfg_wdata_i (hold_threshold, zero ignored)
//
// Taking a frame also updates the hold state. While the hold is
// short of its threshold, progress comes from a restoring divider, one quotient bit a cycle,
// sharing one 33-bit compare/subtract. A frame thus goes from idle to the result state,
// through the divide state when needed, plus any stall on result_o; the next frame is taken once the
// result transaction completes. Reset clears the hold state and sets the threshold to 500000.
module button_hold_tap_detector_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [btd_pkg::TICK_W-1:0]   cfg_wdata_i,
  btd_frame_if.sink                    frame_i,
  btd_result_if.source                 result_o
);

  btd_pkg::btd_state_e state_q, state_d;

  logic                        is_holding_q, is_holding_d;
  logic                        has_reached_q, has_reached_d;
  logic [btd_pkg::TICK_W-1:0]  held_ticks_q, held_ticks_d;
  logic [btd_pkg::BTN_W-1:0]   held_button_q, held_button_d;
  logic [btd_pkg::TICK_W-1:0]  latched_thr_q, latched_thr_d;
  logic [btd_pkg::TICK_W-1:0]  hold_thr_q;

  logic                        acc_q, acc_d;
  logic                        reach_q, reach_d;
  logic                        tap_q, tap_d;
  logic                        rel_q, rel_d;

  logic [btd_pkg::TICK_W-1:0]  rem_q, rem_d;
  logic [btd_pkg::FRAC_W-1:0]  quo_q, quo_d;
  logic [btd_pkg::PROG_W-1:0]  prog_q, prog_d;
  logic [btd_pkg::CNT_W-1:0]   cnt_q, cnt_d;

  logic                        take;
  logic                        in_range;
  logic                        idx_ok;
  logic [btd_pkg::IDX_W-1:0]   idx;
  logic                        cur, prev, starts;
  logic [btd_pkg::TICK_W-1:0]  base;
  logic [btd_pkg::TICK_W:0]    sum;
  logic [btd_pkg::TICK_W-1:0]  sum_sat;
  logic                        reached_pre;
  logic [btd_pkg::TICK_W-1:0]  latch_new;

  logic [btd_pkg::TICK_W:0]    shifted;
  logic [btd_pkg::TICK_W:0]    diff;
  logic                        ge;

  assign take = frame_i.valid && frame_i.ready;

  // Decode the frame against the current hold
  assign in_range = frame_i.action_index < btd_pkg::ACT_W'(btd_pkg::BUTTONS);
  assign idx_ok   = in_range &&
                    (!is_holding_q || (frame_i.action_index == {1'b0, held_button_q}));
  assign idx      = frame_i.action_index[btd_pkg::IDX_W-1:0];
  assign cur      = frame_i.current_mask[idx];
  assign prev     = frame_i.previous_mask[idx];
  assign starts   = cur && (!prev || !is_holding_q);

  // Accumulate held ticks, saturating
  assign base      = starts ? '0 : held_ticks_q;
  assign sum       = {1'b0, base} + {{(btd_pkg::TICK_W + 1 - btd_pkg::DT_W){1'b0}},
                                     frame_i.delta_time};
  assign sum_sat   = sum[btd_pkg::TICK_W] ? '1 : sum[btd_pkg::TICK_W-1:0];
  assign reached_pre = starts ? 1'b0 : has_reached_q;
  assign latch_new = starts ? hold_thr_q : latched_thr_q;

  // Shared divide step: shift remainder, trial subtract the latched threshold
  assign shifted = {rem_q, 1'b0};
  assign diff    = shifted - {1'b0, latched_thr_q};
  assign ge      = shifted >= {1'b0, latched_thr_q};

  // Sequencer and hold state
  always_comb begin
    state_d       = state_q;
    is_holding_d  = is_holding_q;
    has_reached_d = has_reached_q;
    held_ticks_d  = held_ticks_q;
    held_button_d = held_button_q;
    latched_thr_d = latched_thr_q;
    acc_d         = acc_q;
    reach_d       = reach_q;
    tap_d         = tap_q;
    rel_d         = rel_q;
    rem_d         = rem_q;
    quo_d         = quo_q;
    prog_d        = prog_q;
    cnt_d         = cnt_q;
    frame_i.ready = 1'b0;
    result_o.valid = 1'b0;

    // Threshold write also moves the latched value while no button is held
    if (cfg_we_i && (cfg_wdata_i != '0) && !is_holding_q) begin
      latched_thr_d = cfg_wdata_i;
    end

    case (state_q)
      btd_pkg::ST_IDLE: begin
        frame_i.ready = 1'b1;
        if (take) begin
          acc_d   = idx_ok;
          reach_d = 1'b0;
          tap_d   = 1'b0;
          rel_d   = 1'b0;
          if (idx_ok) begin
            if (cur) begin
              is_holding_d  = 1'b1;
              held_ticks_d  = sum_sat;
              latched_thr_d = latch_new;
              if (starts) begin
                held_button_d = idx_ok ? frame_i.action_index[btd_pkg::BTN_W-1:0]
                                       : held_button_q;
              end
              has_reached_d = reached_pre;
              if (!reached_pre && (sum_sat >= latch_new)) begin
                has_reached_d = 1'b1;
                reach_d       = 1'b1;
              end
            end else begin
              tap_d         = is_holding_q && !has_reached_q;
              rel_d         = is_holding_q && has_reached_q;
              is_holding_d  = 1'b0;
              has_reached_d = 1'b0;
              held_ticks_d  = '0;
              held_button_d = btd_pkg::BTN_NONE;
              latched_thr_d = hold_thr_q;
            end
          end
          // Start the divider only while holding and short of the threshold
          if (is_holding_d && !has_reached_d) begin
            rem_d   = held_ticks_d;
            quo_d   = '0;
            cnt_d   = btd_pkg::CNT_W'(btd_pkg::DIV_STEPS);
            state_d = btd_pkg::ST_DIV;
          end else begin
            prog_d  = is_holding_d ? btd_pkg::Q16_ONE : '0;
            state_d = btd_pkg::ST_OUT;
          end
        end
      end
      btd_pkg::ST_DIV: begin
        rem_d = ge ? diff[btd_pkg::TICK_W-1:0] : shifted[btd_pkg::TICK_W-1:0];
        quo_d = {quo_q[btd_pkg::FRAC_W-2:0], ge};
        cnt_d = cnt_q - btd_pkg::CNT_W'(1);
        if (cnt_q == btd_pkg::CNT_W'(1)) begin
          prog_d  = {1'b0, quo_q[btd_pkg::FRAC_W-2:0], ge};
          state_d = btd_pkg::ST_OUT;
        end
      end
      btd_pkg::ST_OUT: begin
        result_o.valid = 1'b1;
        if (result_o.ready) begin
          state_d = btd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = btd_pkg::ST_IDLE;
      end
    endcase
  end

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the tracking state and the configured threshold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_holding_q  <= 1'b0;
      has_reached_q <= 1'b0;
      held_ticks_q  <= '0;
      held_button_q <= btd_pkg::BTN_NONE;
      latched_thr_q <= btd_pkg::THRESHOLD_RESET;
      hold_thr_q    <= btd_pkg::THRESHOLD_RESET;
    end else begin
      is_holding_q  <= is_holding_d;
      has_reached_q <= has_reached_d;
      held_ticks_q  <= held_ticks_d;
      held_button_q <= held_button_d;
      latched_thr_q <= latched_thr_d;
      if (cfg_we_i && (cfg_wdata_i != '0)) begin
        hold_thr_q <= cfg_wdata_i;
      end
    end
  end

  // Advance the divider and hold the result payload
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    reach_q <= reach_d;
    tap_q   <= tap_d;
    rel_q   <= rel_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    prog_q  <= prog_d;
    cnt_q   <= cnt_d;
  end

  // Drive the result payload from the held state
  assign result_o.accepted          = acc_q;
  assign result_o.holding           = is_holding_q;
  assign result_o.threshold_reached = reach_q;
  assign result_o.tapped            = tap_q;
  assign result_o.held_released     = rel_q;
  assign result_o.held_time         = is_holding_q ? held_ticks_q : '0;
  assign result_o.progress          = prog_q;
  assign result_o.locked_index      = held_button_q;

endmodule

>>> sv/btd_checker.sv
// Port-level checks for the button hold/tap detector, bound to the top level.
// Depends on btd_pkg; watches the frame and result channels only.
module btd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        accepted_i,
  input logic                        holding_i,
  input logic                        threshold_reached_i,
  input logic                        tapped_i,
  input logic                        held_released_i,
  input logic [btd_pkg::TICK_W-1:0]  held_time_i,
  input logic [btd_pkg::PROG_W-1:0]  progress_i,
  input logic [btd_pkg::BTN_W-1:0]   locked_index_i
);

  // Drop the input side once a frame is taken
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("frame taken while previous one still in work");

  // Release pulses are exclusive, and no pulse shows on a rejected frame
  a_pulses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(tapped_i && held_released_i) &&
                    (accepted_i || !(threshold_reached_i || tapped_i || held_released_i)))
    else $error("inconsistent pulses");

  // Idle result shows no hold
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !holding_i) |-> (held_time_i == '0) && (progress_i == '0) &&
                                    (locked_index_i == btd_pkg::BTN_NONE) &&
                                    !threshold_reached_i)
    else $error("idle result carries hold data");

  // Progress is full once reached, and never above one
  a_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (progress_i <= btd_pkg::Q16_ONE) &&
                    (!threshold_reached_i || (progress_i == btd_pkg::Q16_ONE)))
    else $error("progress out of range");

  // Hold a stalled result's valid, held time and progress
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(held_time_i) &&
                                      $stable(progress_i))
    else $error("stalled result changed");

endmodule

bind button_hold_tap_detector_top btd_checker u_btd_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (frame_i.valid),
  .in_ready_i          (frame_i.ready),
  .out_valid_i         (result_o.valid),
  .out_ready_i         (result_o.ready),
  .accepted_i          (result_o.accepted),
  .holding_i           (result_o.holding),
  .threshold_reached_i (result_o.threshold_reached),
  .tapped_i            (result_o.tapped),
  .held_released_i     (result_o.held_released),
  .held_time_i         (result_o.held_time),
  .progress_i          (result_o.progress),
  .locked_index_i      (result_o.locked_index)
);
